// ===== rtl/wtws_pkg.sv =====
// ----------------------------------------------------------------------------
// wtws_pkg: shared types and constants of the weekly time window scheduler
// Mode and event codes, register indexes, the controller state type and the
// command and status groups that pass between controller and datapath.
// ----------------------------------------------------------------------------
package wtws_pkg;

	localparam int unsigned SecW       = 17;
	localparam int unsigned DayW       = 3;
	localparam int unsigned MaskW      = 7;
	localparam int unsigned ModeW      = 2;
	localparam int unsigned EventW     = 2;
	localparam int unsigned CfgIdxW    = 3;
	localparam int unsigned CfgDataW   = 17;
	localparam int unsigned DaysPerWeek = 7;
	localparam int unsigned PulseSeconds = 5;
	localparam int unsigned DivSteps   = SecW;
	localparam int unsigned StepCntW   = $clog2(DivSteps);

	localparam logic [ModeW-1:0] MODE_START_STOP = 2'd0;
	localparam logic [ModeW-1:0] MODE_ONE_SHOT   = 2'd1;
	localparam logic [ModeW-1:0] MODE_REPEAT     = 2'd2;

	localparam logic [EventW-1:0] EV_NONE = 2'd0;
	localparam logic [EventW-1:0] EV_ON   = 2'd1;
	localparam logic [EventW-1:0] EV_OFF  = 2'd2;

	localparam logic [CfgIdxW-1:0] REG_MODE     = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_START    = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_END      = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_DURATION = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_REPEAT   = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_DAY_MASK = 3'd5;

	localparam logic [SecW-1:0] REPEAT_RESET = 17'd3600;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CALC,
		ST_DONE
	} wtws_state_t;

	typedef struct packed {
		logic capture;
		logic step;
		logic finish;
	} wtws_cmd_t;

	typedef struct packed {
		logic out_free;
	} wtws_status_t;

endpackage

// ===== rtl/wtws_if.sv =====
// ----------------------------------------------------------------------------
// wtws_if: tick and result channels
// Valid/ready channels carrying one tick in and one scheduler result out.
// ----------------------------------------------------------------------------
interface wtws_tick_if;
	import wtws_pkg::*;

	logic            valid;
	logic            ready;
	logic [SecW-1:0] second_of_day;
	logic [DayW-1:0] weekday;

	modport source (output valid, output second_of_day, output weekday, input ready);
	modport sink (input valid, input second_of_day, input weekday, output ready);
endinterface

interface wtws_result_if;
	import wtws_pkg::*;

	logic              valid;
	logic              ready;
	logic              active;
	logic [EventW-1:0] event_res;

	modport source (output valid, output active, output event_res, input ready);
	modport sink (input valid, input active, input event_res, output ready);
endinterface

// ===== rtl/wtws_ctrl.sv =====
// ----------------------------------------------------------------------------
// wtws_ctrl: scheduler controller
// Sequences tick capture, the serial remainder steps and the final decision.
// ----------------------------------------------------------------------------
module wtws_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	output wtws_pkg::wtws_cmd_t    cmd,
	input  wtws_pkg::wtws_status_t status
);
	import wtws_pkg::*;

	wtws_state_t         state_q;
	wtws_state_t         state_d;
	logic [StepCntW-1:0] cnt_q;
	logic                last_step;

	assign last_step = (cnt_q == StepCntW'(DivSteps - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.capture) begin
				cnt_q <= '0;
			end else if (cmd.step) begin
				cnt_q <= cnt_q + StepCntW'(1);
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_CALC;
			end
			ST_CALC: begin
				if (last_step) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (status.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_ready    = 1'b0;
		cmd.capture = 1'b0;
		cmd.step    = 1'b0;
		cmd.finish  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			ST_CALC: begin
				cmd.step = 1'b1;
			end
			ST_DONE: begin
				cmd.finish = status.out_free;
			end
			default: ;
		endcase
	end

	a_capture_starts_calc: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> (state_q == ST_CALC) && (cnt_q == '0))
		else $error("capture did not start the remainder steps");

	a_full_step_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) && !$past(state_q == ST_DONE) |-> $past(last_step))
		else $error("decision reached before all remainder steps");

endmodule

// ===== rtl/wtws_dp.sv =====
// ----------------------------------------------------------------------------
// wtws_dp: scheduler datapath
// Configuration registers, tick capture, serial remainder unit, window
// decision, active flag and result register.
// ----------------------------------------------------------------------------
module wtws_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [wtws_pkg::CfgIdxW-1:0]    cfg_index,
	input  logic [wtws_pkg::CfgDataW-1:0]   cfg_wdata,
	input  logic [wtws_pkg::SecW-1:0]       second_of_day,
	input  logic [wtws_pkg::DayW-1:0]       weekday,
	input  wtws_pkg::wtws_cmd_t              cmd,
	output wtws_pkg::wtws_status_t           status,
	wtws_result_if.source                   result
);
	import wtws_pkg::*;

	// configuration
	logic [ModeW-1:0] mode_q;
	logic [SecW-1:0]  start_q;
	logic [SecW-1:0]  end_q;
	logic [SecW-1:0]  dur_q;
	logic [SecW-1:0]  rep_q;
	logic [MaskW-1:0] mask_q;

	// tick working registers
	logic [SecW-1:0]  now_q;
	logic [DayW-1:0]  day_q;
	logic             dneg_q;
	logic [SecW-1:0]  dvd_q;
	logic [SecW-1:0]  rem_q;

	// result
	logic              active_q;
	logic [EventW-1:0] event_q;
	logic              out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_START_STOP;
			start_q <= '0;
			end_q   <= '0;
			dur_q   <= '0;
			rep_q   <= REPEAT_RESET;
			mask_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MODE:     mode_q  <= cfg_wdata[ModeW-1:0];
				REG_START:    start_q <= cfg_wdata[SecW-1:0];
				REG_END:      end_q   <= cfg_wdata[SecW-1:0];
				REG_DURATION: dur_q   <= cfg_wdata[SecW-1:0];
				REG_REPEAT:   rep_q   <= cfg_wdata[SecW-1:0];
				REG_DAY_MASK: mask_q  <= cfg_wdata[MaskW-1:0];
				default: ;
			endcase
		end
	end

	// magnitude of now - start, sign kept apart
	logic            cap_neg;
	logic [SecW-1:0] cap_mag;
	assign cap_neg = second_of_day < start_q;
	assign cap_mag = cap_neg ? (start_q - second_of_day) : (second_of_day - start_q);

	// one restoring remainder step
	logic [SecW:0] shifted;
	logic          fits;
	assign shifted = {rem_q, dvd_q[SecW-1]};
	assign fits    = shifted >= {1'b0, rep_q};

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			now_q  <= second_of_day;
			day_q  <= weekday;
			dneg_q <= cap_neg;
			dvd_q  <= cap_mag;
			rem_q  <= '0;
		end else if (cmd.step) begin
			dvd_q <= {dvd_q[SecW-2:0], 1'b0};
			rem_q <= fits ? SecW'(shifted - {1'b0, rep_q}) : shifted[SecW-1:0];
		end
	end

	// weekday enables
	logic [DayW-1:0] yday;
	logic            en_today;
	logic            en_yday;
	assign en_today = (day_q < DayW'(DaysPerWeek)) && mask_q[day_q];
	assign yday     = (day_q == '0) ? DayW'(DaysPerWeek - 1) : (day_q - DayW'(1));
	assign en_yday  = mask_q[yday];

	// window decision
	logic            tgt_set;
	logic            tgt_val;
	logic [SecW:0]   pulse_end;
	assign pulse_end = {1'b0, start_q} + (SecW + 1)'(PulseSeconds);

	always_comb begin
		tgt_set = 1'b0;
		tgt_val = 1'b0;
		unique case (mode_q)
			MODE_START_STOP: begin
				if (end_q >= start_q) begin
					if (en_today) begin
						if (start_q > now_q && end_q >= now_q) begin
							tgt_set = 1'b1;
							tgt_val = 1'b0;
						end
						if (start_q <= now_q && end_q > now_q) begin
							tgt_set = 1'b1;
							tgt_val = 1'b1;
						end
						if (start_q <= now_q && end_q < now_q) begin
							tgt_set = 1'b1;
							tgt_val = 1'b0;
						end
					end
				end else begin
					if (en_yday) begin
						if (start_q >= now_q && end_q > now_q) begin
							tgt_set = 1'b1;
							tgt_val = 1'b1;
						end
						if (start_q >= now_q && end_q < now_q) begin
							tgt_set = 1'b1;
							tgt_val = 1'b0;
						end
					end
					if (en_today && start_q <= now_q && end_q < now_q) begin
						tgt_set = 1'b1;
						tgt_val = 1'b1;
					end
				end
			end
			MODE_ONE_SHOT: begin
				tgt_set = 1'b1;
				tgt_val = en_today && (start_q <= now_q) && (pulse_end >= {1'b0, now_q});
			end
			MODE_REPEAT: begin
				// truncated remainder lies in [0, duration) exactly when inside a window
				tgt_set = 1'b1;
				tgt_val = (rep_q != '0) && en_today && (!dneg_q || rem_q == '0)
					&& (rem_q < dur_q);
			end
			default: ;
		endcase
	end

	assign status.out_free = !out_valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
			if (tgt_set) active_q <= tgt_val;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			if (tgt_set && tgt_val && !active_q) begin
				event_q <= EV_ON;
			end else if (tgt_set && !tgt_val && active_q) begin
				event_q <= EV_OFF;
			end else begin
				event_q <= EV_NONE;
			end
		end
	end

	assign result.valid     = out_valid_q;
	assign result.active    = active_q;
	assign result.event_res = event_q;

	a_on_event_active: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && event_q == EV_ON |-> active_q)
		else $error("activate event with flag low");

	a_off_event_inactive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && event_q == EV_OFF |-> !active_q)
		else $error("deactivate event with flag high");

	a_finish_loads_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> out_valid_q)
		else $error("finished tick left no result");

	a_flag_only_on_finish: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.finish |=> $stable(active_q))
		else $error("active flag changed outside a decision");

endmodule

// ===== rtl/weekly_time_window_scheduler.sv =====
// ----------------------------------------------------------------------------
// weekly_time_window_scheduler: weekday time-of-day scheduler
// Decides per tick whether a schedule output is on, in start/stop, one-shot
// or repeating-window mode, and reports activate and deactivate events.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake        | payload
//  ---------+-----------+------------------+--------------------------------
//  tick     | in        | valid / ready    | second_of_day[16:0], weekday[2:0]
//  result   | out       | valid / ready    | active, event_res[1:0]
//  cfg      | in        | cfg_we (no wait) | cfg_index[2:0], cfg_wdata[16:0]
//
// a tick runs through acceptance, 17 steps of the serial remainder unit
// (one quotient bit per cycle) and the decision
// the remainder unit runs in every mode, so the tick time does not depend on data
// the result sits in an output register: the next tick is accepted while it
// waits; a decision waits only if the previous result is still not taken
// reset clears the active flag and loads the register reset values at once
// ----------------------------------------------------------------------------
module weekly_time_window_scheduler (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [wtws_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [wtws_pkg::CfgDataW-1:0] cfg_wdata,
	wtws_tick_if.sink                     tick,
	wtws_result_if.source                 result
);
	import wtws_pkg::*;

	// command and status between controller and datapath
	wtws_cmd_t    cmd;
	wtws_status_t status;

	// controller owns the tick handshake, payload goes straight to the datapath
	wtws_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (tick.valid),
		.in_ready (tick.ready),
		.cmd      (cmd),
		.status   (status)
	);

	// datapath holds configuration, remainder unit, flag and result register
	wtws_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.second_of_day (tick.second_of_day),
		.weekday       (tick.weekday),
		.cmd           (cmd),
		.status        (status),
		.result        (result)
	);

endmodule

// ===== sim/tb_weekly_time_window_scheduler.sv =====
// ----------------------------------------------------------------------------
// tb_weekly_time_window_scheduler: self-checking bench for the week scheduler
// Ticks go in on a valid/ready channel and each one is predicted in the bench
// from a private copy of the registers and the active flag. The predicted
// results wait in a queue and are compared field by field as results leave
// the block. A short directed part hits the edge cases of every mode. Random
// phases follow, each with its own register setting, under one of three
// patterns of sender and receiver stalls.
// ----------------------------------------------------------------------------
module tb_weekly_time_window_scheduler;

	import wtws_pkg::*;

	localparam int CycleLimit = 400000;
	localparam int MaxReports = 10;
	localparam int SettleCycles = 20;
	localparam int RandomPhases = 26;
	localparam int TicksPerPhase = 50;

	// mode code with no rule behind it; the flag just holds
	localparam logic [ModeW-1:0] MODE_UNUSED = 2'd3;

	typedef enum logic [1:0] {
		TGT_HOLD,
		TGT_OFF,
		TGT_ON
	} target_t;

	typedef struct packed {
		logic              active;
		logic [EventW-1:0] ev;
	} outcome_t;

	// predicted scheduler: register copy, active flag and the outcomes still owed
	class window_tracker;
		logic [ModeW-1:0] mode;
		logic [SecW-1:0]  start_sec;
		logic [SecW-1:0]  stop_sec;
		logic [SecW-1:0]  dur_sec;
		logic [SecW-1:0]  rep_sec;
		logic [MaskW-1:0] day_mask;
		logic             flag;
		outcome_t         pending[$];
		int unsigned      mismatches;

		function new();
			mode = MODE_START_STOP;
			start_sec = '0;
			stop_sec = '0;
			dur_sec = '0;
			rep_sec = REPEAT_RESET;
			day_mask = '0;
			flag = 1'b0;
			mismatches = 0;
		endfunction

		function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
			case (idx)
				REG_MODE:     mode = val[ModeW-1:0];
				REG_START:    start_sec = val[SecW-1:0];
				REG_END:      stop_sec = val[SecW-1:0];
				REG_DURATION: dur_sec = val[SecW-1:0];
				REG_REPEAT:   rep_sec = val[SecW-1:0];
				REG_DAY_MASK: day_mask = val[MaskW-1:0];
				default: ;
			endcase
		endfunction

		// weekday seven is never enabled
		function logic day_on(int unsigned d);
			if (d >= DaysPerWeek)
				return 1'b0;
			return day_mask[d];
		endfunction

		function void note_tick(logic [SecW-1:0] sec, logic [DayW-1:0] day);
			longint      now, s, e, r, k, w;
			int unsigned today, prev_day;
			target_t     tgt;
			outcome_t    o;
			now = longint'(sec);
			s = longint'(start_sec);
			e = longint'(stop_sec);
			r = longint'(rep_sec);
			today = day;
			prev_day = (today + DaysPerWeek - 1) % DaysPerWeek;
			tgt = TGT_HOLD;
			case (mode)
				MODE_START_STOP: begin
					if (e >= s) begin
						// window inside one day; now equal to the end holds
						if (day_on(today)) begin
							if (s > now && e >= now) tgt = TGT_OFF;
							if (s <= now && e > now) tgt = TGT_ON;
							if (s <= now && e < now) tgt = TGT_OFF;
						end
					end else begin
						// window across midnight: the morning part belongs to yesterday
						if (day_on(prev_day)) begin
							if (s >= now && e > now) tgt = TGT_ON;
							if (s >= now && e < now) tgt = TGT_OFF;
						end
						if (day_on(today) && s <= now && e < now) tgt = TGT_ON;
					end
				end
				MODE_ONE_SHOT: begin
					// pulse end is not wrapped past midnight
					tgt = (day_on(today) && s <= now && s + longint'(PulseSeconds) >= now) ?
						TGT_ON : TGT_OFF;
				end
				MODE_REPEAT: begin
					tgt = TGT_OFF;
					if (r != 0 && day_on(today)) begin
						// signed division truncates toward zero before the start time
						k = (now - s) / r;
						w = s + k * r;
						if (w <= now && w + longint'(dur_sec) > now) tgt = TGT_ON;
					end
				end
				default: ;
			endcase
			o.ev = EV_NONE;
			if (tgt == TGT_ON && !flag) begin
				flag = 1'b1;
				o.ev = EV_ON;
			end else if (tgt == TGT_OFF && flag) begin
				flag = 1'b0;
				o.ev = EV_OFF;
			end
			o.active = flag;
			pending.push_back(o);
		endfunction

		function void check_result(logic act, logic [EventW-1:0] ev);
			outcome_t want;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= MaxReports)
					$display("unexpected result: active %0b event_res %0d", act, ev);
				return;
			end
			want = pending.pop_front();
			if (act !== want.active) begin
				mismatches++;
				if (mismatches <= MaxReports)
					$display("active mismatch: expected %0b actual %0b", want.active, act);
			end
			if (ev !== want.ev) begin
				mismatches++;
				if (mismatches <= MaxReports)
					$display("event_res mismatch: expected %0d actual %0d", want.ev, ev);
			end
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic [CfgIdxW-1:0]  cfg_index;
	logic [CfgDataW-1:0] cfg_wdata;

	wtws_tick_if   tick_ch();
	wtws_result_if result_ch();

	window_tracker tracker;
	int            tx_idle_pct;
	int            rx_idle_pct;
	int            cycle_count;
	longint        clock_cursor;

	weekly_time_window_scheduler dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.tick      (tick_ch),
		.result    (result_ch)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// register write; the bench copy follows at the same edge
	task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		tracker.set_reg(idx, val);
	endtask

	task automatic apply_settings(logic [ModeW-1:0] m, logic [SecW-1:0] st,
		logic [SecW-1:0] sp, logic [SecW-1:0] du, logic [SecW-1:0] rp, logic [MaskW-1:0] mk);
		write_reg(REG_MODE, CfgDataW'(m));
		write_reg(REG_START, st);
		write_reg(REG_END, sp);
		write_reg(REG_DURATION, du);
		write_reg(REG_REPEAT, rp);
		write_reg(REG_DAY_MASK, CfgDataW'(mk));
		cfg_we <= 1'b0;
	endtask

	// one tick transaction; called at a rising edge, returns at the accepting edge
	task automatic send_tick(logic [SecW-1:0] sec, logic [DayW-1:0] day);
		if ($urandom_range(0, 99) < tx_idle_pct) begin
			tick_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		tick_ch.valid <= 1'b1;
		tick_ch.second_of_day <= sec;
		tick_ch.weekday <= day;
		@(posedge clk);
		while (!tick_ch.ready) @(posedge clk);
		tracker.note_tick(sec, day);
	endtask

	// block is idle once every owed result is out and a tick time has passed
	task automatic wait_quiet();
		tick_ch.valid <= 1'b0;
		while (tracker.pending.size() != 0) @(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	// register times: mostly in the day, sometimes the extremes or any 17-bit value
	function automatic logic [SecW-1:0] pick_config_second();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return 17'd86399;
			2: return SecW'($urandom_range(0, 131071));
			default: return SecW'($urandom_range(0, 86399));
		endcase
	endfunction

	// tick times cluster around the edges of the current window so the flag toggles
	function automatic logic [SecW-1:0] pick_second();
		int unsigned sel;
		longint      base;
		sel = $urandom_range(0, 9);
		case (sel)
			0, 1: base = $urandom_range(0, 86399);
			2: base = $urandom_range(0, 131071);
			3: base = longint'(tracker.start_sec) + $urandom_range(0, 6) - 3;
			4: base = longint'(tracker.stop_sec) + $urandom_range(0, 6) - 3;
			5: base = longint'(tracker.start_sec) + PulseSeconds + $urandom_range(0, 4) - 2;
			6, 7: begin
				// near the opening or closing of a repeated window
				base = longint'(tracker.start_sec) +
					longint'($urandom_range(0, 30)) * longint'(tracker.rep_sec) +
					$urandom_range(0, 4) - 2;
				if (sel == 7)
					base += longint'(tracker.dur_sec);
			end
			default: begin
				// clock-like run of rising times through the window
				clock_cursor += $urandom_range(1, 3);
				base = clock_cursor;
			end
		endcase
		return base[SecW-1:0];
	endfunction

	task automatic random_settings();
		logic [ModeW-1:0] m;
		logic [SecW-1:0]  rp;
		logic [MaskW-1:0] mk;
		case ($urandom_range(0, 8))
			0, 1, 2: m = MODE_START_STOP;
			3, 4:    m = MODE_ONE_SHOT;
			5, 6, 7: m = MODE_REPEAT;
			default: m = MODE_UNUSED;
		endcase
		case ($urandom_range(0, 9))
			0:       rp = '0;
			7, 8:    rp = SecW'($urandom_range(121, 86399));
			9:       rp = SecW'($urandom_range(0, 131071));
			default: rp = SecW'($urandom_range(1, 120));
		endcase
		case ($urandom_range(0, 5))
			0:       mk = '0;
			1:       mk = '1;
			default: mk = MaskW'($urandom_range(0, 127));
		endcase
		apply_settings(m, pick_config_second(), pick_config_second(),
			($urandom_range(0, 3) == 0) ? pick_config_second() : SecW'($urandom_range(0, 30)),
			rp, mk);
	endtask

	// result side: check on every accepted transaction, ready toggles at random
	initial begin
		result_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (result_ch.valid && result_ch.ready)
				tracker.check_result(result_ch.active, result_ch.event_res);
			result_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
		end
	end

	// watchdog
	initial begin
		cycle_count = 0;
		while (cycle_count < CycleLimit) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb_weekly_time_window_scheduler failed");
		$finish;
	end

	initial begin
		logic [DayW-1:0] wd;
		tracker = new();
		tx_idle_pct = 20;
		rx_idle_pct = 85;
		clock_cursor = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		tick_ch.valid = 1'b0;
		tick_ch.second_of_day = '0;
		tick_ch.weekday = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset values: start/stop with an empty day mask only holds
		send_tick(17'd0, 3'd0);
		send_tick(17'h1FFFF, 3'd7);

		// repeat period left at its reset value of one hour
		wait_quiet();
		write_reg(REG_MODE, CfgDataW'(MODE_REPEAT));
		write_reg(REG_DURATION, 17'd5);
		write_reg(REG_DAY_MASK, 17'h7F);
		cfg_we <= 1'b0;
		send_tick(17'd3602, 3'd1);
		send_tick(17'd3605, 3'd2);

		// window inside one day: before, start, end holds, after, weekday seven holds
		wait_quiet();
		apply_settings(MODE_START_STOP, 17'd100, 17'd200, 17'd0, 17'd3600, 7'h7F);
		send_tick(17'd99, 3'd3);
		send_tick(17'd100, 3'd3);
		send_tick(17'd200, 3'd3);
		send_tick(17'd201, 3'd3);
		send_tick(17'd150, 3'd7);

		// window across midnight with only Sunday enabled
		wait_quiet();
		apply_settings(MODE_START_STOP, 17'd86000, 17'd3600, 17'd0, 17'd3600, 7'h01);
		send_tick(17'd100, 3'd1);
		send_tick(17'd3600, 3'd1);
		send_tick(17'd5000, 3'd1);
		send_tick(17'd86000, 3'd0);
		send_tick(17'd86399, 3'd6);

		// one-shot just before midnight: the pulse runs past the last second of the day
		wait_quiet();
		apply_settings(MODE_ONE_SHOT, 17'd86397, 17'd0, 17'd0, 17'd3600, 7'h7F);
		send_tick(17'd86396, 3'd5);
		send_tick(17'd86397, 3'd5);
		send_tick(17'd86402, 3'd5);
		send_tick(17'd86403, 3'd5);

		// repeated window, including a time before the start
		wait_quiet();
		apply_settings(MODE_REPEAT, 17'd1000, 17'd0, 17'd10, 17'd60, 7'h7F);
		send_tick(17'd900, 3'd0);
		send_tick(17'd1005, 3'd0);
		send_tick(17'd1075, 3'd0);

		// zero period never opens a window
		wait_quiet();
		apply_settings(MODE_REPEAT, 17'd0, 17'd0, 17'd86399, 17'd0, 7'h7F);
		send_tick(17'd10, 3'd0);

		// unused mode code holds, registers at their widest values
		wait_quiet();
		apply_settings(MODE_UNUSED, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 7'h7F);
		send_tick(17'd1, 3'd0);

		// random phases: slow receiver first, then slow sender, then full rate
		for (int phase = 0; phase < RandomPhases; phase++) begin
			if (phase < RandomPhases / 3) begin
				tx_idle_pct = 20;
				rx_idle_pct = 85;
			end else if (phase < 2 * RandomPhases / 3) begin
				tx_idle_pct = 85;
				rx_idle_pct = 20;
			end else begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			wait_quiet();
			random_settings();
			clock_cursor = longint'(tracker.start_sec) - 10;
			repeat (TicksPerPhase) begin
				wd = ($urandom_range(0, 7) == 7) ? 3'd7 : DayW'($urandom_range(0, 6));
				send_tick(pick_second(), wd);
			end
		end

		wait_quiet();
		if (tracker.mismatches == 0 && tracker.pending.size() == 0) begin
			$display("tb_weekly_time_window_scheduler passed");
		end else begin
			$display("tb_weekly_time_window_scheduler failed");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/wtws_pkg.sv
rtl/wtws_if.sv
rtl/wtws_ctrl.sv
rtl/wtws_dp.sv
rtl/weekly_time_window_scheduler.sv
sim/tb_weekly_time_window_scheduler.sv
